// File: sv/vn_pkg.sv
package vn_pkg;

   // datapath widths for 32-bit components
   localparam int NumLanes = 4;
   localparam int MagW     = 32;   // component magnitude, up to 2^31
   localparam int SqW      = 64;   // square of one magnitude
   localparam int SumW     = 65;   // sum of up to four squares, up to 2^64
   localparam int RemW     = 128;  // a^2 * 2^60 and the trial products
   localparam int QsW      = 96;   // partial quotient times sum of squares
   localparam int QW       = 31;   // quotient magnitude bits
   localparam int OutW     = 32;   // result component width
   localparam int SqShift  = 60;   // scale of a^2 against the sum

   // dimension codes of the mode field
   localparam logic [1:0] ModeDim2 = 2'd0;

   typedef logic [SumW-1:0] sum_type;
   typedef logic [RemW-1:0] rem_type;
   typedef logic [QW-1:0]   quot_type;

endpackage

// File: sv/vn_front.sv
module vn_front #(
   parameter int CompWidth = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [1:0]              mode,
   input  logic [31:0]             comp [vn_pkg::NumLanes],
   output vn_pkg::sum_type         s_out,
   output vn_pkg::rem_type         r_out [vn_pkg::NumLanes],
   output logic                    neg_out [vn_pkg::NumLanes],
   output logic                    zero_out
);
   import vn_pkg::*;

   logic [MagW-1:0] mag_ff  [NumLanes];
   logic            nega_ff [NumLanes];
   logic [SqW-1:0]  sq_ff   [NumLanes];
   logic            negb_ff [NumLanes];
   sum_type         s_ff;
   rem_type         r_ff    [NumLanes];
   logic            negc_ff [NumLanes];
   logic            zero_ff;
   logic            used    [NumLanes];
   sum_type         s_in;

   // decode which components take part
   always_comb begin
      used[0] = 1'b1;
      used[1] = 1'b1;
      used[2] = (mode != ModeDim2);
      used[3] = mode[1];
   end

   // take magnitude and sign of the low CompWidth bits
   for (genvar i = 0; i < NumLanes; i++) begin : g_mag
      logic [CompWidth-1:0] v;
      logic [CompWidth-1:0] m;
      always_comb begin
         v = comp[i][CompWidth-1:0];
         m = v[CompWidth-1] ? (~v + 1'b1) : v;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[i]  <= used[i] ? MagW'(m) : '0;
            nega_ff[i] <= used[i] & v[CompWidth-1];
            sq_ff[i]   <= mag_ff[i] * mag_ff[i];
            negb_ff[i] <= nega_ff[i];
            r_ff[i]    <= RemW'(sq_ff[i]) << SqShift;
            negc_ff[i] <= negb_ff[i];
         end
      end
   end

   // sum the squares
   always_comb begin
      s_in = SumW'(sq_ff[0]) + SumW'(sq_ff[1]) + SumW'(sq_ff[2]) + SumW'(sq_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff    <= s_in;
         zero_ff <= (s_in == '0);
      end
   end

   assign s_out    = s_ff;
   assign r_out    = r_ff;
   assign neg_out  = negc_ff;
   assign zero_out = zero_ff;

endmodule

// File: sv/vn_lane.sv
module vn_lane (
   input  logic             clock,
   input  logic             en,
   input  vn_pkg::rem_type  r_in,
   input  vn_pkg::sum_type  s_in,
   input  logic             neg_in,
   output vn_pkg::quot_type q_out,
   output logic             neg_out
);
   import vn_pkg::*;

   // one stage per quotient bit, most significant first
   rem_type         p_ff   [QW];
   logic [QsW-1:0]  qs_ff  [QW];
   quot_type        q_ff   [QW];
   rem_type         r_ff   [QW];
   sum_type         s_ff   [QW];
   logic            neg_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      localparam int B = QW - 1 - k;
      rem_type        p_cur, r_cur, cand, p_in;
      logic [QsW-1:0] qs_cur, qs_in;
      quot_type       q_cur, q_in;
      sum_type        s_cur;
      logic           neg_cur, take;

      if (k == 0) begin : g_first
         always_comb begin
            p_cur   = '0;
            qs_cur  = '0;
            q_cur   = '0;
            r_cur   = r_in;
            s_cur   = s_in;
            neg_cur = neg_in;
         end
      end else begin : g_next
         always_comb begin
            p_cur   = p_ff[k-1];
            qs_cur  = qs_ff[k-1];
            q_cur   = q_ff[k-1];
            r_cur   = r_ff[k-1];
            s_cur   = s_ff[k-1];
            neg_cur = neg_ff[k-1];
         end
      end

      // try (q + 2^B)^2 * S against a^2 * 2^60
      always_comb begin
         cand  = p_cur + (RemW'(qs_cur) << (B + 1)) + (RemW'(s_cur) << (2 * B));
         take  = (cand <= r_cur);
         p_in  = take ? cand : p_cur;
         qs_in = take ? (qs_cur + (QsW'(s_cur) << B)) : qs_cur;
         q_in  = take ? (q_cur | (QW'(1) << B)) : q_cur;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[k]   <= p_in;
            qs_ff[k]  <= qs_in;
            q_ff[k]   <= q_in;
            r_ff[k]   <= r_cur;
            s_ff[k]   <= s_cur;
            neg_ff[k] <= neg_cur;
         end
      end
   end

   assign q_out   = q_ff[QW-1];
   assign neg_out = neg_ff[QW-1];

endmodule

// File: sv/vector_normalizer.sv
// Vector normalizer: one 2-, 3- or 4-component Q16.16 vector per item on the
// req_ channel, one Q2.30 unit vector per item on the rsp_ channel.
// mode selects the dimension; unused components come out as zero, and a
// vector of zero length gives all zeros with rsp_zero_length set.
// Both channels use valid/ready. A new item is taken every cycle while the
// receiver keeps up: throughput is one item per clock.
// From acceptance to rsp_valid an item passes three front stages
// (magnitude, square, sum), then 31 stages per lane, one for each quotient
// bit, then the output register. Four lanes work side by side, one per
// component, and the output stage merges sign and the zero-length flag.
// The whole pipeline advances together; while a result waits on rsp_ready
// every stage holds and req_ready is low.
// Reset clears all valid bits and holds req_ready low; the pipeline is empty
// and ready afterwards.
module vector_normalizer #(
   parameter int COMPONENT_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_x_in,
   input  logic signed [31:0] req_y_in,
   input  logic signed [31:0] req_z_in,
   input  logic signed [31:0] req_w_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_out,
   output logic signed [31:0] rsp_y_out,
   output logic signed [31:0] rsp_z_out,
   output logic signed [31:0] rsp_w_out,
   output logic               rsp_zero_length
);
   import vn_pkg::*;

   localparam int FrontDepth = 3;
   localparam int Depth      = FrontDepth + QW;

   logic            adv;
   logic [31:0]     comp [NumLanes];
   sum_type         s_c;
   rem_type         r_c   [NumLanes];
   logic            neg_c [NumLanes];
   logic            zero_c;
   quot_type        q_l   [NumLanes];
   logic            neg_l [NumLanes];
   logic            valid_ff [Depth];
   logic            zero_ff  [QW];
   logic            rsp_valid_ff;
   logic [OutW-1:0] res_ff [NumLanes];
   logic [OutW-1:0] res_in [NumLanes];
   logic            zl_ff;

   // advance everything when the output register can take a new item
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !reset;

   assign comp[0] = req_x_in;
   assign comp[1] = req_y_in;
   assign comp[2] = req_z_in;
   assign comp[3] = req_w_in;

   vn_front #(.CompWidth(COMPONENT_WIDTH)) u_front (
      .clock    (clock),
      .en       (adv),
      .mode     (req_mode),
      .comp     (comp),
      .s_out    (s_c),
      .r_out    (r_c),
      .neg_out  (neg_c),
      .zero_out (zero_c)
   );

   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      vn_lane u_lane (
         .clock   (clock),
         .en      (adv),
         .r_in    (r_c[i]),
         .s_in    (s_c),
         .neg_in  (neg_c[i]),
         .q_out   (q_l[i]),
         .neg_out (neg_l[i])
      );

      // apply sign, force zero for a zero-length vector
      always_comb begin
         res_in[i] = '0;
         if (!zero_ff[QW-1]) begin
            res_in[i] = neg_l[i] ? (OutW'(0) - OutW'(q_l[i])) : OutW'(q_l[i]);
         end
      end
   end

   // track item valid through all stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Depth; k++) begin
            valid_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < Depth; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         rsp_valid_ff <= valid_ff[Depth-1];
      end
   end

   // delay the zero-length flag alongside the lanes, load the output
   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= zero_c;
         for (int k = 1; k < QW; k++) begin
            zero_ff[k] <= zero_ff[k-1];
         end
         for (int i = 0; i < NumLanes; i++) begin
            res_ff[i] <= res_in[i];
         end
         zl_ff <= zero_ff[QW-1];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_out       = res_ff[0];
   assign rsp_y_out       = res_ff[1];
   assign rsp_z_out       = res_ff[2];
   assign rsp_w_out       = res_ff[3];
   assign rsp_zero_length = zl_ff;

endmodule
